@@ design/masked_ring_average_smoother_assert.svh @@
// Assertion macros shared by the smoother RTL.
`ifndef MASKED_RING_AVERAGE_SMOOTHER_ASSERT_SVH
`define MASKED_RING_AVERAGE_SMOOTHER_ASSERT_SVH
`ifndef SYNTHESIS
`define MRAS_ASSERT_IMPLIES(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("smoother check failed");
`define MRAS_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("smoother check failed");
`else
`define MRAS_ASSERT_IMPLIES(name, clk, rst, cond, expr)
`define MRAS_ASSERT_NEXT(name, clk, rst, cond, expr)
`endif
`endif

@@ design/mras_pkg.sv @@
// Types and constants shared by the masked ring average smoother.
`default_nettype none

package mras_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int PIXEL_BITS    = 16;
   localparam int MIN_DIM       = 3;
   localparam int WIN_SIZE      = 3;
   localparam int MEAN8_SHIFT   = 3;

   localparam int MASK_BITS     = 8;
   localparam int WIDTH_BITS    = 12;
   localparam int HEIGHT_BITS   = 13;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = HEIGHT_BITS;
   localparam int POS_BITS      = $clog2(MAX_WIDTH * HEIGHT_LIMIT);

   localparam int APB_DATA_BITS = 32;
   localparam int APB_ADDR_BITS = 4;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH   = 2'd0,
      REG_FRAME_HEIGHT  = 2'd1,
      REG_CONTOUR_CODE  = 2'd2,
      REG_HOLD_CONTOURS = 2'd3
   } mras_reg_type;

   typedef struct packed {
      logic                  flag;
      logic [PIXEL_BITS-1:0] height;
   } mras_entry_type;

   typedef struct packed {
      mras_entry_type top;
      mras_entry_type mid;
   } mras_pair_type;

   typedef struct packed {
      logic result;
      logic last;
      logic top;
      logic bot;
      logic left;
      logic right;
   } mras_class_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  eff_width;
      logic [HEIGHT_BITS-1:0] eff_height;
      logic [POS_BITS-1:0]    last_index;
      logic [MASK_BITS-1:0]   contour_code;
      logic                   hold_contours;
   } mras_cfg_type;

endpackage

`default_nettype wire

@@ design/mras_req_if.sv @@
// Input channel: raster pixel or drain tick.
`default_nettype none

interface mras_req_if import mras_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [PIXEL_BITS-1:0] height_value;
   logic [MASK_BITS-1:0]  line_value;

   modport source (output valid, mode, height_value, line_value, input ready);
   modport sink (input valid, mode, height_value, line_value, output ready);
endinterface

`default_nettype wire

@@ design/mras_rsp_if.sv @@
// Result channel: smoothed pixel and frame end flag.
`default_nettype none

interface mras_rsp_if import mras_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] smoothed_height;
   logic                  frame_end;

   modport source (output valid, smoothed_height, frame_end, input ready);
   modport sink (input valid, smoothed_height, frame_end, output ready);
endinterface

`default_nettype wire

@@ design/mras_csr.sv @@
// APB register bank with clamped frame geometry.
`default_nettype none

module mras_csr import mras_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_ADDR_BITS-1:0] paddr,
   input  logic [APB_DATA_BITS-1:0] pwdata,
   output logic [APB_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output mras_cfg_type             cfg,
   output logic                     width_changed
);

   localparam int AREA_BITS = WIDTH_BITS + HEIGHT_BITS;

   logic [WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic [MASK_BITS-1:0]   contour_code_ff, contour_code_in;
   logic                   hold_contours_ff, hold_contours_in;
   logic [WIDTH_BITS-1:0]  eff_width_ff, eff_width_in;
   logic [HEIGHT_BITS-1:0] eff_height_ff, eff_height_in;
   logic [POS_BITS-1:0]    last_index_ff, last_index_in;
   logic                   width_changed_ff, width_changed_in;
   logic                   wr;
   mras_reg_type           reg_sel;
   logic [AREA_BITS-1:0]   area;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign reg_sel = mras_reg_type'(paddr[APB_ADDR_BITS-1:2]);

   always_comb begin
      frame_width_in   = frame_width_ff;
      frame_height_in  = frame_height_ff;
      contour_code_in  = contour_code_ff;
      hold_contours_in = hold_contours_ff;
      width_changed_in = 1'b0;
      if (wr) begin
         case (reg_sel)
            REG_FRAME_WIDTH: begin
               frame_width_in   = pwdata[WIDTH_BITS-1:0];
               width_changed_in = 1'b1;
            end
            REG_FRAME_HEIGHT:  frame_height_in  = pwdata[HEIGHT_BITS-1:0];
            REG_CONTOUR_CODE:  contour_code_in  = pwdata[MASK_BITS-1:0];
            REG_HOLD_CONTOURS: hold_contours_in = pwdata[0];
            default: ;
         endcase
      end
   end

   // clamp to the supported geometry
   always_comb begin
      if (frame_width_in < WIDTH_BITS'(MIN_DIM)) begin
         eff_width_in = WIDTH_BITS'(MIN_DIM);
      end else if (frame_width_in > WIDTH_BITS'(MAX_WIDTH)) begin
         eff_width_in = WIDTH_BITS'(MAX_WIDTH);
      end else begin
         eff_width_in = frame_width_in;
      end
      if (frame_height_in < HEIGHT_BITS'(MIN_DIM)) begin
         eff_height_in = HEIGHT_BITS'(MIN_DIM);
      end else if (frame_height_in > HEIGHT_BITS'(HEIGHT_LIMIT)) begin
         eff_height_in = HEIGHT_BITS'(HEIGHT_LIMIT);
      end else begin
         eff_height_in = frame_height_in;
      end
      area          = AREA_BITS'(eff_width_in) * AREA_BITS'(eff_height_in);
      last_index_in = area[POS_BITS-1:0] - POS_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= WIDTH_BITS'(MAX_WIDTH);
         frame_height_ff  <= HEIGHT_BITS'(HEIGHT_LIMIT);
         contour_code_ff  <= '0;
         hold_contours_ff <= 1'b1;
         eff_width_ff     <= WIDTH_BITS'(MAX_WIDTH);
         eff_height_ff    <= HEIGHT_BITS'(HEIGHT_LIMIT);
         last_index_ff    <= '1;
         width_changed_ff <= 1'b0;
      end else begin
         frame_width_ff   <= frame_width_in;
         frame_height_ff  <= frame_height_in;
         contour_code_ff  <= contour_code_in;
         hold_contours_ff <= hold_contours_in;
         eff_width_ff     <= eff_width_in;
         eff_height_ff    <= eff_height_in;
         last_index_ff    <= last_index_in;
         width_changed_ff <= width_changed_in;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_sel)
         REG_FRAME_WIDTH:   prdata = APB_DATA_BITS'(frame_width_ff);
         REG_FRAME_HEIGHT:  prdata = APB_DATA_BITS'(frame_height_ff);
         REG_CONTOUR_CODE:  prdata = APB_DATA_BITS'(contour_code_ff);
         REG_HOLD_CONTOURS: prdata = APB_DATA_BITS'(hold_contours_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.eff_width     = eff_width_ff;
   assign cfg.eff_height    = eff_height_ff;
   assign cfg.last_index    = last_index_ff;
   assign cfg.contour_code  = contour_code_ff;
   assign cfg.hold_contours = hold_contours_ff;
   assign width_changed     = width_changed_ff;

endmodule

`default_nettype wire

@@ design/mras_divider.sv @@
// Restoring divider: splits the output position into row and column.
`default_nettype none

module mras_divider import mras_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [POS_BITS-1:0]   dividend,
   input  logic [WIDTH_BITS-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [POS_BITS-1:0]   quotient,
   output logic [COL_BITS-1:0]   remainder
);

   localparam int CNT_BITS = $clog2(POS_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(POS_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [POS_BITS-1:0]   quot_ff, quot_in;
   logic [COL_BITS-1:0]   rem_ff, rem_in;
   logic [COL_BITS:0]     shifted;
   logic [COL_BITS:0]     diff;

   // one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      shifted  = {rem_ff, quot_ff[POS_BITS-1]};
      diff     = shifted - divisor;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (shifted >= divisor) begin
            rem_in  = diff[COL_BITS-1:0];
            quot_in = {quot_ff[POS_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[COL_BITS-1:0];
            quot_in = {quot_ff[POS_BITS-2:0], 1'b0};
         end
         count_in = count_ff + CNT_BITS'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

@@ design/mras_line_buffer.sv @@
// Two line buffers in one memory, registered read with write forwarding.
`default_nettype none

module mras_line_buffer import mras_pkg::*; (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [COL_BITS-1:0] rd_addr,
   input  logic                wr_en,
   input  logic [COL_BITS-1:0] wr_addr,
   input  mras_pair_type       wr_data,
   output mras_pair_type       rd_data
);

   mras_pair_type mem [MAX_WIDTH];
   mras_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same column written and read in one cycle: take the new word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/mras_filter.sv @@
// 3x3 window registers and the neighborhood mean arithmetic.
`default_nettype none

module mras_filter import mras_pkg::*; (
   input  logic                  clock,
   input  logic                  shift_en,
   input  mras_entry_type        col_top,
   input  mras_entry_type        col_mid,
   input  mras_entry_type        col_bot,
   input  mras_class_type        class_in,
   input  logic                  hold_contours,
   output mras_class_type        class_out,
   output logic [PIXEL_BITS-1:0] filtered
);

   localparam int SUM3_BITS  = PIXEL_BITS + 2;
   localparam int SUM8_BITS  = PIXEL_BITS + MEAN8_SHIFT;
   localparam int DIV3_SHIFT = SUM3_BITS + 1;
   localparam int PROD_BITS  = SUM3_BITS + DIV3_SHIFT;
   localparam logic [DIV3_SHIFT-1:0] DIV3_MUL = DIV3_SHIFT'(((2 ** DIV3_SHIFT) + 2) / 3);

   mras_entry_type        win_ff [WIN_SIZE][WIN_SIZE];
   mras_class_type        class_ff;
   logic [PIXEL_BITS-1:0] trio_a, trio_b, trio_c;
   logic [SUM3_BITS-1:0]  sum3;
   logic [SUM8_BITS-1:0]  sum8;
   logic [PROD_BITS-1:0]  prod;
   logic [PIXEL_BITS-1:0] third;

   // row 0 is the oldest line, column 0 the oldest pixel
   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int r = 0; r < WIN_SIZE; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= col_top;
         win_ff[1][2] <= col_mid;
         win_ff[2][2] <= col_bot;
         class_ff     <= class_in;
      end
   end

   always_comb begin
      if (class_ff.top) begin
         trio_a = win_ff[2][0].height;
         trio_b = win_ff[2][1].height;
         trio_c = win_ff[2][2].height;
      end else if (class_ff.bot) begin
         trio_a = win_ff[0][0].height;
         trio_b = win_ff[0][1].height;
         trio_c = win_ff[0][2].height;
      end else if (class_ff.left) begin
         trio_a = win_ff[0][2].height;
         trio_b = win_ff[1][2].height;
         trio_c = win_ff[2][2].height;
      end else begin
         trio_a = win_ff[0][0].height;
         trio_b = win_ff[1][0].height;
         trio_c = win_ff[2][0].height;
      end
      sum3  = SUM3_BITS'(trio_a) + SUM3_BITS'(trio_b) + SUM3_BITS'(trio_c);
      // divide by three as multiply by reciprocal, exact over the sum range
      prod  = PROD_BITS'(sum3) * PROD_BITS'(DIV3_MUL);
      third = prod[DIV3_SHIFT +: PIXEL_BITS];
      sum8  = SUM8_BITS'(win_ff[0][0].height) + SUM8_BITS'(win_ff[0][1].height)
            + SUM8_BITS'(win_ff[0][2].height) + SUM8_BITS'(win_ff[1][0].height)
            + SUM8_BITS'(win_ff[1][2].height) + SUM8_BITS'(win_ff[2][0].height)
            + SUM8_BITS'(win_ff[2][1].height) + SUM8_BITS'(win_ff[2][2].height);
   end

   always_comb begin
      if (class_ff.top && class_ff.left) begin
         filtered = win_ff[2][2].height;
      end else if (class_ff.top && class_ff.right) begin
         filtered = win_ff[2][0].height;
      end else if (class_ff.bot && class_ff.left) begin
         filtered = win_ff[0][2].height;
      end else if (class_ff.bot && class_ff.right) begin
         filtered = win_ff[0][0].height;
      end else if (hold_contours && win_ff[1][1].flag) begin
         filtered = win_ff[1][1].height;
      end else if (class_ff.top || class_ff.bot || class_ff.left || class_ff.right) begin
         filtered = third;
      end else begin
         filtered = sum8[SUM8_BITS-1 -: PIXEL_BITS];
      end
   end

   assign class_out = class_ff;

endmodule

`default_nettype wire

@@ design/masked_ring_average_smoother.sv @@
// Top level of the masked ring average smoother.
//
// One 3x3 smoothing pass over a height map streamed in raster order.
// req_if carries one word per pixel (mode 0) or a drain tick (mode 1);
// rsp_if carries the smoothed pixels in raster order, frame_end marking
// the last one. Both are valid/ready channels.
// The result for pixel p is produced by the word at stream position
// p + W + 1; after the last pixel of a frame, W + 1 drain ticks (or
// further pixels, whose data is dropped) push out the tail. Drain ticks
// before the frame is complete are taken and ignored.
// Throughput: one word per clock while rsp_if is not stalled and no divide
// runs. A result shows on rsp_if after the line buffer read, the window
// shift and the output register.
// A stalled rsp_if holds its word while the inner stages fill: up to two more
// result-producing words are taken before req_if.ready drops.
// Configuration goes over the APB port while the stream is idle; this binds
// the user, the block does not enforce it. A write to frame_width recomputes
// the output row/column with a bit-serial divide that holds req_if.ready low.
// Reset is synchronous; it clears the counters and the pipeline and loads
// the register defaults. Line buffer contents are not cleared.
`default_nettype none
`include "masked_ring_average_smoother_assert.svh"

module masked_ring_average_smoother import mras_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   mras_req_if.sink                 req_if,
   mras_rsp_if.source               rsp_if,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [APB_ADDR_BITS-1:0] paddr,
   input  logic [APB_DATA_BITS-1:0] pwdata,
   output logic [APB_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   mras_cfg_type          cfg;
   logic                  width_changed;

   logic                  div_busy, div_done;
   logic [POS_BITS-1:0]   div_row;
   logic [COL_BITS-1:0]   div_col;

   // stream position counters
   logic [COL_BITS-1:0]   in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]   in_row_ff, in_row_in;
   logic [POS_BITS-1:0]   out_pos_ff, out_pos_in;
   logic [POS_BITS-1:0]   out_row_ff, out_row_in;
   logic [COL_BITS-1:0]   out_col_ff, out_col_in;

   // stage 1: word taken, line buffer read in flight
   logic                  p1_valid_ff, p1_valid_in;
   mras_entry_type        p1_entry_ff;
   logic [COL_BITS-1:0]   p1_addr_ff;
   mras_class_type        p1_class_ff;

   // stage 2: window holds the neighborhood
   logic                  p2_valid_ff, p2_valid_in;
   mras_class_type        p2_class;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_BITS-1:0] rsp_height_ff;
   logic                  rsp_end_ff;

   logic                  accept, complete, do_shift, emit;
   logic                  adv1, adv2, free1, free2, rsp_take;
   mras_entry_type        acc_entry;
   mras_class_type        acc_class;
   mras_pair_type         lb_rd_data, lb_wr_data;
   logic [PIXEL_BITS-1:0] filtered;
   logic [COL_BITS:0]     in_col_step, out_col_step;
   logic [POS_BITS-1:0]   bot_row;

   mras_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .cfg           (cfg),
      .width_changed (width_changed)
   );

   // new width: re-split out_pos into row and column
   mras_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (width_changed),
      .dividend  (out_pos_ff),
      .divisor   (cfg.eff_width),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_row),
      .remainder (div_col)
   );

   // pipeline flow: a word-less stage 2 item always drains
   assign rsp_take = rsp_valid_ff && rsp_if.ready;
   assign adv2     = p2_valid_ff && (!p2_class.result || !rsp_valid_ff || rsp_if.ready);
   assign free2    = !p2_valid_ff || adv2;
   assign adv1     = p1_valid_ff && free2;
   assign free1    = !p1_valid_ff || adv1;

   assign req_if.ready = free1 && !div_busy && !div_done && !width_changed;
   assign accept       = req_if.valid && req_if.ready;

   // a word after the frame is full acts as a drain tick with a zero entry
   assign complete = (in_row_ff >= cfg.eff_height);
   assign do_shift = accept && (complete || !req_if.mode);
   assign emit     = do_shift
                  && ((in_row_ff >= ROW_BITS'(2))
                      || ((in_row_ff == ROW_BITS'(1)) && (in_col_ff != '0)));

   assign acc_entry.height = complete ? '0 : req_if.height_value;
   assign acc_entry.flag   = !complete && (req_if.line_value == cfg.contour_code);

   assign bot_row = POS_BITS'(cfg.eff_height) - POS_BITS'(1);

   assign in_col_step  = {1'b0, in_col_ff} + (COL_BITS+1)'(1);
   assign out_col_step = {1'b0, out_col_ff} + (COL_BITS+1)'(1);

   always_comb begin
      acc_class.result = emit;
      acc_class.last   = out_pos_ff >= cfg.last_index;
      acc_class.top    = (out_row_ff == '0);
      acc_class.bot    = (out_row_ff >= bot_row);
      acc_class.left   = (out_col_ff == '0);
      acc_class.right  = ({1'b0, out_col_ff} >= (cfg.eff_width - WIDTH_BITS'(1)));
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_pos_in = out_pos_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (do_shift) begin
         if (in_col_step >= cfg.eff_width) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_BITS'(1);
         end else begin
            in_col_in = in_col_step[COL_BITS-1:0];
         end
      end
      if (emit) begin
         if (acc_class.last) begin
            // frame done: restart all positions
            in_col_in  = '0;
            in_row_in  = '0;
            out_pos_in = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            out_pos_in = out_pos_ff + POS_BITS'(1);
            if (out_col_step >= cfg.eff_width) begin
               out_col_in = '0;
               out_row_in = out_row_ff + POS_BITS'(1);
            end else begin
               out_col_in = out_col_step[COL_BITS-1:0];
            end
         end
      end
      if (div_done) begin
         out_row_in = div_row;
         out_col_in = div_col;
      end
   end

   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (do_shift) begin
         p1_valid_in = 1'b1;
      end else if (adv1) begin
         p1_valid_in = 1'b0;
      end
      p2_valid_in = p2_valid_ff;
      if (adv1) begin
         p2_valid_in = 1'b1;
      end else if (adv2) begin
         p2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (adv2 && p2_class.result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_pos_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_pos_ff   <= out_pos_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_shift) begin
         p1_entry_ff <= acc_entry;
         p1_addr_ff  <= in_col_ff;
         p1_class_ff <= acc_class;
      end
      if (adv2 && p2_class.result) begin
         rsp_height_ff <= filtered;
         rsp_end_ff    <= p2_class.last;
      end
   end

   // older line moves up, the new word becomes the middle line
   assign lb_wr_data.top = lb_rd_data.mid;
   assign lb_wr_data.mid = p1_entry_ff;

   mras_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (do_shift),
      .rd_addr (in_col_ff),
      .wr_en   (adv1),
      .wr_addr (p1_addr_ff),
      .wr_data (lb_wr_data),
      .rd_data (lb_rd_data)
   );

   mras_filter u_filter (
      .clock         (clock),
      .shift_en      (adv1),
      .col_top       (lb_rd_data.top),
      .col_mid       (lb_rd_data.mid),
      .col_bot       (p1_entry_ff),
      .class_in      (p1_class_ff),
      .hold_contours (cfg.hold_contours),
      .class_out     (p2_class),
      .filtered      (filtered)
   );

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.smoothed_height = rsp_height_ff;
   assign rsp_if.frame_end       = rsp_end_ff;

   // stage 2 is never overwritten while it holds an item
   `MRAS_ASSERT_IMPLIES(a_stage2_hold, clock, reset, p2_valid_ff && !adv2, !adv1)
   // no word enters while the row/column split is being recomputed
   `MRAS_ASSERT_IMPLIES(a_no_accept_divide, clock, reset, div_busy, !accept)
   // a result needs at least one full line and one pixel buffered
   `MRAS_ASSERT_IMPLIES(a_emit_after_line, clock, reset, emit, in_row_ff != '0)
   // the last pixel of a frame returns every position to the origin
   `MRAS_ASSERT_NEXT(a_frame_wrap, clock, reset, emit && acc_class.last,
                     out_pos_ff == '0 && in_row_ff == '0 && in_col_ff == '0)

endmodule

`default_nettype wire

@@ verif/masked_ring_average_smoother_tb.sv @@
// Self-checking testbench for the masked ring average smoother.
`timescale 1ns / 1ps

module masked_ring_average_smoother_tb;
   import mras_pkg::*;

   // One expected smoothed pixel, in raster order.
   typedef struct {
      logic [PIXEL_BITS-1:0] height;
      logic                  frame_end;
   } smoothed_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [APB_ADDR_BITS-1:0] paddr;
   logic [APB_DATA_BITS-1:0] pwdata;
   logic [APB_DATA_BITS-1:0] prdata;
   logic                     pready;

   mras_req_if req_if ();
   mras_rsp_if rsp_if ();

   masked_ring_average_smoother u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #6 clock = ~clock;

   // Mirror of the block: line buffers, 3x3 window, stream counters and the
   // register shadow. Updated once for every word accepted on req_if.
   mras_entry_type line_mem [0:2*MAX_WIDTH-1];
   mras_entry_type win [0:8];
   int unsigned    in_col;
   int unsigned    in_row;
   int unsigned    out_idx;
   logic [WIDTH_BITS-1:0]  cfg_width;
   logic [HEIGHT_BITS-1:0] cfg_height;
   logic [MASK_BITS-1:0]   cfg_code;
   logic                   cfg_hold;

   smoothed_pixel_type pending_pixels [$];

   int errors          = 0;
   int fed_words       = 0;   // words that moved the stream (not ignored ticks)
   int frames_sent     = 0;
   int pixels_checked  = 0;
   int idle_pct        = 0;   // idle burst chance: per req word, per rsp cycle
   int ready_hold      = 0;

   function automatic int unsigned eff_width();
      if (cfg_width < MIN_DIM) return MIN_DIM;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height < MIN_DIM) return MIN_DIM;
      if (cfg_height > HEIGHT_LIMIT) return HEIGHT_LIMIT;
      return cfg_height;
   endfunction

   // Filter for the window centre at (r, c). Window index is row*3 + col;
   // row 2 is the newest line, column 2 the newest pixel.
   function automatic logic [PIXEL_BITS-1:0] window_mean(int unsigned r, int unsigned c,
                                                         int unsigned w, int unsigned h);
      logic        on_top, on_bot, on_lft, on_rgt;
      int unsigned s;
      on_top = (r == 0);
      on_bot = (r >= h - 1);
      on_lft = (c == 0);
      on_rgt = (c >= w - 1);
      // corners copy the diagonal inner neighbor, contour or not
      if (on_top && on_lft) return win[8].height;
      if (on_top && on_rgt) return win[6].height;
      if (on_bot && on_lft) return win[2].height;
      if (on_bot && on_rgt) return win[0].height;
      if (cfg_hold && win[4].flag) return win[4].height;
      if (on_top) begin
         s = win[6].height + win[7].height + win[8].height;
         return PIXEL_BITS'(s / 3);
      end
      if (on_bot) begin
         s = win[0].height + win[1].height + win[2].height;
         return PIXEL_BITS'(s / 3);
      end
      if (on_lft) begin
         s = win[2].height + win[5].height + win[8].height;
         return PIXEL_BITS'(s / 3);
      end
      if (on_rgt) begin
         s = win[0].height + win[3].height + win[6].height;
         return PIXEL_BITS'(s / 3);
      end
      s = win[0].height + win[1].height + win[2].height + win[3].height
        + win[5].height + win[6].height + win[7].height + win[8].height;
      return PIXEL_BITS'(s >> MEAN8_SHIFT);
   endfunction

   // Advance the mirror by one accepted word; queue a pixel if one leaves.
   task automatic track_word(input logic mode, input logic [PIXEL_BITS-1:0] hgt,
                             input logic [MASK_BITS-1:0] msk);
      int unsigned        w, h, x, p;
      logic               emits;
      mras_entry_type     entry, top_e, mid_e;
      smoothed_pixel_type px;
      w = eff_width();
      h = eff_height();
      // a drain tick before the frame is complete does nothing
      if (in_row < h && mode) return;
      fed_words++;
      if (in_row >= h) begin
         entry = '0;   // after the frame, pixel data is dropped
      end else begin
         entry.height = hgt;
         entry.flag   = (msk == cfg_code);
      end
      emits = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      x = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
      top_e = line_mem[x];
      mid_e = line_mem[MAX_WIDTH + x];
      line_mem[x] = mid_e;
      line_mem[MAX_WIDTH + x] = entry;
      for (int r = 0; r < 3; r++) begin
         win[r*3]   = win[r*3 + 1];
         win[r*3+1] = win[r*3 + 2];
      end
      win[2] = top_e;
      win[5] = mid_e;
      win[8] = entry;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emits) return;
      p = out_idx;
      px.height    = window_mean(p / w, p % w, w, h);
      px.frame_end = (p >= w * h - 1);
      if (px.frame_end) begin
         in_col  = 0;
         in_row  = 0;
         out_idx = 0;
      end else begin
         out_idx = p + 1;
      end
      pending_pixels.push_back(px);
   endtask

   function automatic logic [APB_DATA_BITS-1:0] csr_shadow(input mras_reg_type which);
      case (which)
         REG_FRAME_WIDTH:   return APB_DATA_BITS'(cfg_width);
         REG_FRAME_HEIGHT:  return APB_DATA_BITS'(cfg_height);
         REG_CONTOUR_CODE:  return APB_DATA_BITS'(cfg_code);
         REG_HOLD_CONTOURS: return APB_DATA_BITS'(cfg_hold);
         default:           return '0;
      endcase
   endfunction

   task automatic csr_read(input mras_reg_type which, output logic [APB_DATA_BITS-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {which, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      data = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write a register, mirror it, and read it back.
   task automatic csr_write(input mras_reg_type which, input logic [APB_DATA_BITS-1:0] value);
      logic [APB_DATA_BITS-1:0] rd;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_FRAME_WIDTH:   cfg_width  = value[WIDTH_BITS-1:0];
         REG_FRAME_HEIGHT:  cfg_height = value[HEIGHT_BITS-1:0];
         REG_CONTOUR_CODE:  cfg_code   = value[MASK_BITS-1:0];
         REG_HOLD_CONTOURS: cfg_hold   = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      csr_read(which, rd);
      if (rd !== csr_shadow(which)) begin
         $display("%0t: register %s readback, expected %h got %h",
                  $time, which.name(), csr_shadow(which), rd);
         errors++;
      end
   endtask

   // Offer one word on req_if, with an optional idle burst in front.
   // valid is left high on return so back-to-back words need no gap.
   task automatic send_word(input logic mode, input logic [PIXEL_BITS-1:0] hgt,
                            input logic [MASK_BITS-1:0] msk);
      @(negedge clock);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.height_value <= hgt;
      req_if.line_value   <= msk;
      do @(posedge clock); while (!req_if.ready);
      track_word(mode, hgt, msk);
   endtask

   // Drop valid, let every expected pixel arrive, then a few spare cycles so
   // any ignored trailing tick has left the pipe before a register write.
   task automatic wait_for_results();
      int guard;
      guard = 0;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_pixels.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (pending_pixels.size() != 0) begin
         $display("%0t: %0d smoothed pixels never arrived", $time, pending_pixels.size());
         errors++;
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [PIXEL_BITS-1:0] pick_height();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   // Lean toward the contour code so holding gets exercised.
   function automatic logic [MASK_BITS-1:0] pick_mask();
      if ($urandom_range(99) < 35) return cfg_code;
      return MASK_BITS'($urandom);
   endfunction

   // One whole frame of random pixels at the current size, then W+1 words of
   // drain mixing ticks and dropped pixels. With noise, stray ticks land
   // mid-frame and after the frame, where the block ignores them.
   task automatic send_frame(input bit noisy);
      int unsigned w, h;
      w = eff_width();
      h = eff_height();
      for (int unsigned n = 0; n < w * h; n++) begin
         if (noisy && $urandom_range(99) < 4) send_word(1'b1, pick_height(), pick_mask());
         send_word(1'b0, pick_height(), pick_mask());
      end
      for (int unsigned n = 0; n <= w; n++)
         send_word(1'($urandom_range(1)), pick_height(), pick_mask());
      if (noisy) repeat ($urandom_range(2)) send_word(1'b1, pick_height(), pick_mask());
      frames_sent++;
   endtask

   // Result side: random stall bursts on rsp_if.ready.
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         ready_hold--;
         rsp_if.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         ready_hold = $urandom_range(8, 0);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each accepted result word with the oldest expected pixel.
   always @(posedge clock) begin
      smoothed_pixel_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result word, height %h frame_end %b",
                     $time, rsp_if.smoothed_height, rsp_if.frame_end);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (rsp_if.smoothed_height !== want.height) begin
               $display("%0t: smoothed_height mismatch, expected %h got %h",
                        $time, want.height, rsp_if.smoothed_height);
               errors++;
            end
            if (rsp_if.frame_end !== want.frame_end) begin
               $display("%0t: frame_end mismatch, expected %b got %b",
                        $time, want.frame_end, rsp_if.frame_end);
               errors++;
            end
         end
      end
   end

   // Register values straight out of reset.
   task automatic test_reset_values();
      logic [APB_DATA_BITS-1:0] rd;
      mras_reg_type             which;
      which = which.first();
      do begin
         csr_read(which, rd);
         if (rd !== csr_shadow(which)) begin
            $display("%0t: register %s after reset, expected %h got %h",
                     $time, which.name(), csr_shadow(which), rd);
            errors++;
         end
         which = which.next();
      end while (which != which.first());
   endtask

   // Two hand-built 3x3 frames: extremes of height and mask, contour pixels
   // on a corner, an edge and the center, early and late drain ticks, and a
   // pixel after the frame that only serves as drain.
   task automatic test_directed_frames();
      logic [PIXEL_BITS-1:0] hts [0:8];
      logic [MASK_BITS-1:0]  mks [0:8];
      idle_pct = 0;
      // undersized writes clamp to 3x3
      csr_write(REG_FRAME_WIDTH, 32'd2);
      csr_write(REG_FRAME_HEIGHT, 32'd0);
      csr_write(REG_CONTOUR_CODE, 32'h0000_00A5);
      csr_write(REG_HOLD_CONTOURS, 32'd1);
      hts = '{16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF, 16'h8001,
              16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFE};
      mks = '{8'hA5, 8'hA5, 8'h00, 8'hFF, 8'hA5, 8'h5A, 8'hA4, 8'hA5, 8'h00};
      send_word(1'b1, 16'hFFFF, 8'hFF);          // tick before any pixel: ignored
      for (int i = 0; i < 9; i++) send_word(1'b0, hts[i], mks[i]);
      send_word(1'b0, 16'hBEEF, 8'hA5);          // data dropped, acts as drain
      repeat (3) send_word(1'b1, 16'h0000, 8'h00);
      send_word(1'b1, 16'h5555, 8'hA5);          // after frame end: ignored
      frames_sent++;
      wait_for_results();

      // holding off, zero code matches every mask, all-ones sums
      csr_write(REG_FRAME_WIDTH, 32'd3);
      csr_write(REG_CONTOUR_CODE, 32'h0000_0000);
      csr_write(REG_HOLD_CONTOURS, 32'd0);
      for (int i = 0; i < 9; i++) send_word(1'b0, (i == 4) ? 16'h0000 : 16'hFFFF, 8'h00);
      repeat (4) send_word(1'b1, 16'hFFFF, 8'hFF);
      frames_sent++;
      wait_for_results();
   endtask

   // Geometry from out-of-range register values, then one wide, short frame.
   task automatic test_dimension_extremes();
      idle_pct = 10;
      csr_write(REG_FRAME_WIDTH, 32'd1);        // clamps to 3
      csr_write(REG_FRAME_HEIGHT, 32'd2);       // clamps to 3
      csr_write(REG_CONTOUR_CODE, 32'h0000_00FF);
      csr_write(REG_HOLD_CONTOURS, 32'd1);
      send_frame(1'b1);
      wait_for_results();
      csr_write(REG_FRAME_WIDTH, 32'd96);
      csr_write(REG_FRAME_HEIGHT, 32'd3);
      csr_write(REG_HOLD_CONTOURS, 32'd0);
      send_frame(1'b1);
      wait_for_results();
   endtask

   // Random small frames with random settings until enough words have gone in.
   task automatic test_random_frames();
      int          start_words;
      int unsigned w, h;
      start_words = fed_words;
      while (fed_words - start_words < 1100) begin
         case ($urandom_range(3))
            0:       idle_pct = 0;
            1:       idle_pct = 8;
            2:       idle_pct = 20;
            default: idle_pct = 35;
         endcase
         case ($urandom_range(19))
            0:       w = $urandom_range(130, 41);
            1, 2, 3: w = $urandom_range(40, 13);
            default: w = $urandom_range(12, 3);
         endcase
         h = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(9, 3);
         csr_write(REG_FRAME_WIDTH, w);
         csr_write(REG_FRAME_HEIGHT, h);
         case ($urandom_range(9))
            0:       csr_write(REG_CONTOUR_CODE, 32'h0000_0000);
            1:       csr_write(REG_CONTOUR_CODE, 32'h0000_00FF);
            default: csr_write(REG_CONTOUR_CODE, $urandom);
         endcase
         csr_write(REG_HOLD_CONTOURS, $urandom);
         send_frame(1'b1);
         wait_for_results();
      end
   endtask

   // Closing frames with both sides running flat out.
   task automatic test_unstalled_tail();
      idle_pct = 0;
      repeat (2) begin
         csr_write(REG_FRAME_WIDTH, $urandom_range(16, 3));
         csr_write(REG_FRAME_HEIGHT, $urandom_range(8, 3));
         csr_write(REG_HOLD_CONTOURS, 32'd1);
         send_frame(1'b0);
         wait_for_results();
      end
   endtask

   initial begin
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_if.valid        = 1'b0;
      req_if.mode         = 1'b0;
      req_if.height_value = '0;
      req_if.line_value   = '0;
      rsp_if.ready        = 1'b0;
      // mirror starts at the reset state of the block
      for (int i = 0; i < 2 * MAX_WIDTH; i++) line_mem[i] = '0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      in_col     = 0;
      in_row     = 0;
      out_idx    = 0;
      cfg_width  = WIDTH_BITS'(MAX_WIDTH);
      cfg_height = HEIGHT_BITS'(HEIGHT_LIMIT);
      cfg_code   = '0;
      cfg_hold   = 1'b1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_frames();
      test_dimension_extremes();
      test_random_frames();
      test_unstalled_tail();

      $display("Ran %0d frames, %0d stream words, %0d smoothed pixels compared",
               frames_sent, fed_words, pixels_checked);
      $display("Sizes 3x3 up to 130 wide and 20 tall, clamped sizes, holding on and off, drain noise");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ masked_ring_average_smoother.f @@
+incdir+design
design/mras_pkg.sv
design/mras_req_if.sv
design/mras_rsp_if.sv
design/mras_csr.sv
design/mras_divider.sv
design/mras_line_buffer.sv
design/mras_filter.sv
design/masked_ring_average_smoother.sv
verif/masked_ring_average_smoother_tb.sv
